// ===== hdl/sapq_pkg.sv =====
// Shared constants and types for the sorted-array priority queue.
package sapq_pkg;

	localparam int CAPACITY_DEF      = 64;
	localparam int PRIORITY_BITS_DEF = 32;
	localparam int PAYLOAD_BITS_DEF  = 32;

	localparam logic [1:0] CMD_INSERT     = 2'd0;
	localparam logic [1:0] CMD_REMOVE_TOP = 2'd1;
	localparam logic [1:0] CMD_REMOVE_MAT = 2'd2;
	localparam logic [1:0] CMD_FIND       = 2'd3;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_FULL        = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
	localparam logic [1:0] ST_COUNT_EXCEEDS = 2'd3;

endpackage

// ===== hdl/sapq_store.sv =====
// Dual entry memory: priority and payload, one write and one read port, registered read.
module sapq_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== hdl/sorted_array_priority_queue_core.sv =====
// Top level of the sorted-array priority queue: command sequencer around one entry memory.
// Each command is processed alone. Every command ends by reading the top entry back from
// the memory. Insert scans from the top down, shifting each larger entry up one rank, and
// writes the new entry above the first entry not larger than it, or at rank 0; a full store
// is not scanned. Find scans down from the top to the first match. Remove matching scans
// down from the top to the match, then shifts the entries above it down one rank each.
// Remove-highest does no scan. All cost comes from the single read and single write port
// of the entry memory. A new command is taken only after the result has been accepted and
// the sequencer has returned to idle through S_DONE, so no new command is accepted while
// a result is pending. The memory is not cleared after reset: ranks at or above the count
// are never read for a result.
module sorted_array_priority_queue_core
	import sapq_pkg::*;
#(
	parameter int CAPACITY      = CAPACITY_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] priority_req,
	input  logic [31:0] payload,
	input  logic        match_payload,
	input  logic [6:0]  remove_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  found_rank,
	output logic [31:0] top_priority,
	output logic [31:0] top_payload,
	output logic [6:0]  entry_count,
	output logic        is_empty
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;
	localparam int XW = (CW > 7) ? CW : 7;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1; // address issued, data next cycle
	localparam logic [2:0] S_SHIFT = 3'd2; // remove: move entry above down
	localparam logic [2:0] S_TOPRD = 3'd3;
	localparam logic [2:0] S_TOPW  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]               state_q;
	logic [1:0]               cmd_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;
	logic                     usep_q;
	logic [CW-1:0]            held_q;
	logic [CW-1:0]            pos_q;   // rank under read (scan) or target (shift)
	logic                     pend_q;  // read data valid this cycle
	logic [1:0]               st_q;
	logic [AW-1:0]            rank_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [EW-1:0] wr_data, rd_data;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic [PAYLOAD_BITS-1:0]  rd_pay;
	logic hit, le;

	sapq_store #(.DEPTH(CAPACITY), .WIDTH(EW)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign rd_prio = rd_data[EW-1:PAYLOAD_BITS];
	assign rd_pay  = rd_data[PAYLOAD_BITS-1:0];
	assign hit = (rd_prio == prio_q) && (!usep_q || rd_pay == pay_q);
	assign le  = (rd_prio <= prio_q);
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	// Memory port control.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = rd_data;
		rd_addr = pos_q[AW-1:0];
		unique case (state_q)
			S_SCAN: begin
				// scan passed rank 0 or store empty: place the new entry at rank 0
				if (cmd_q == CMD_INSERT && pos_q == '1) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = {prio_q, pay_q};
				end
				if (pend_q && cmd_q == CMD_INSERT) begin
					if (!le) begin
						wr_en   = 1'b1;
						wr_addr = AW'(pos_q + 1'b1);
					end else begin
						wr_en   = 1'b1;
						wr_addr = AW'(pos_q + 1'b1);
						wr_data = {prio_q, pay_q};
					end
				end
				if (pos_q == '0 && pend_q && cmd_q == CMD_INSERT && !le) begin
					rd_addr = '0;
				end
			end
			S_SHIFT: begin
				rd_addr = AW'(pos_q + 1'b1);
				if (pend_q) begin
					wr_en = 1'b1;
				end
			end
			S_TOPRD: rd_addr = AW'(held_q - 1'b1);
			S_IDLE, S_TOPW, S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q  <= cmd;
						prio_q <= PRIORITY_BITS'(priority_req);
						pay_q  <= PAYLOAD_BITS'(payload);
						usep_q <= match_payload;
						st_q   <= ST_OK;
						rank_q <= '0;
						pend_q <= 1'b0;
						unique case (cmd)
							CMD_INSERT: begin
								if (held_q == CW'(CAPACITY)) begin
									st_q    <= ST_FULL;
									state_q <= S_TOPRD;
								end else if (held_q == '0) begin
									pos_q   <= '1; // write lands at rank 0
									state_q <= S_SCAN;
								end else begin
									pos_q   <= CW'(held_q - 1'b1);
									state_q <= S_SCAN;
								end
							end
							CMD_REMOVE_TOP: begin
								if (XW'(remove_count) > XW'(held_q)) begin
									st_q <= ST_COUNT_EXCEEDS;
								end else begin
									held_q <= held_q - CW'(remove_count);
								end
								state_q <= S_TOPRD;
							end
							default: begin
								if (held_q == '0) begin
									st_q    <= ST_NOT_FOUND;
									state_q <= S_TOPRD;
								end else begin
									pos_q   <= CW'(held_q - 1'b1);
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (cmd_q == CMD_INSERT && pos_q == '1) begin
						// empty store or scan passed rank 0: entry written at rank 0
						state_q <= S_TOPRD;
						held_q  <= held_q + 1'b1;
					end else if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (cmd_q == CMD_INSERT) begin
						if (le) begin
							rank_q  <= AW'(pos_q + 1'b1);
							held_q  <= held_q + 1'b1;
							state_q <= S_TOPRD;
							pend_q  <= 1'b0;
						end else if (pos_q == '0) begin
							pos_q  <= '1;
							pend_q <= 1'b0;
						end else begin
							pos_q  <= pos_q - 1'b1;
							pend_q <= 1'b0;
						end
					end else if (hit) begin
						rank_q <= pos_q[AW-1:0];
						pend_q <= 1'b0;
						if (cmd_q == CMD_FIND) begin
							state_q <= S_TOPRD;
						end else if (CW'(pos_q + 1'b1) == held_q) begin
							held_q  <= held_q - 1'b1;
							state_q <= S_TOPRD;
						end else begin
							state_q <= S_SHIFT;
						end
					end else begin
						pend_q <= 1'b0;
						if (pos_q == '0) begin
							st_q    <= ST_NOT_FOUND;
							state_q <= S_TOPRD;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				S_SHIFT: begin
					// read rank pos+1, then write it at pos
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (CW'(pos_q + 2'd2) == held_q) begin
							held_q  <= held_q - 1'b1;
							state_q <= S_TOPRD;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_TOPRD: state_q <= S_TOPW;
				S_TOPW: begin
					status      <= st_q;
					found_rank  <= (st_q == ST_OK) ? 6'(rank_q) : 6'd0;
					entry_count <= 7'(held_q);
					is_empty    <= (held_q == '0);
					top_priority <= (held_q == '0) ? 32'd0 : 32'(rd_prio);
					top_payload  <= (held_q == '0) ? 32'd0 : 32'(rd_pay);
					out_valid   <= 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_held_bound;
		@(posedge clk) disable iff (!arst_n) held_q <= CW'(CAPACITY);
	endproperty
	assert property (p_held_bound) else $error("count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result shown in acceptance cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOPW) |=> (out_valid && (is_empty == (entry_count == 7'd0))))
		else $error("empty flag disagrees with count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (found_rank == 6'd0))
		else $error("rank nonzero on failure");
endmodule

// ===== test/tb.sv =====
// Testbench for the sorted-array priority queue core: random and directed commands, scoreboard check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sapq_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  found_rank;
		logic [31:0] top_priority;
		logic [31:0] top_payload;
		logic [6:0]  entry_count;
		logic        is_empty;
	} queue_result_t;

	class queue_scoreboard;
		logic [31:0] prio_mem[DEPTH];
		logic [31:0] pay_mem[DEPTH];
		int held;
		queue_result_t pending[$];
		int errors;

		function void clear();
			held = 0;
			pending.delete();
			errors = 0;
		endfunction

		function int match_rank(logic [31:0] p, logic [31:0] d, logic mp);
			for (int r = held - 1; r >= 0; r--)
				if (prio_mem[r] == p && (!mp || pay_mem[r] == d))
					return r;
			return -1;
		endfunction

		function void note_command(logic [1:0] c, logic [31:0] p, logic [31:0] d,
				logic mp, logic [6:0] n);
			queue_result_t res;
			int rank;
			int hit;
			rank = 0;
			res.status = ST_OK;
			case (c)
				CMD_INSERT: begin
					if (held >= DEPTH) begin
						res.status = ST_FULL;
					end else begin
						while (rank < held && prio_mem[rank] <= p)
							rank++;
						for (int i = held; i > rank; i--) begin
							prio_mem[i] = prio_mem[i-1];
							pay_mem[i] = pay_mem[i-1];
						end
						prio_mem[rank] = p;
						pay_mem[rank] = d;
						held++;
					end
				end
				CMD_REMOVE_TOP: begin
					if (n > held)
						res.status = ST_COUNT_EXCEEDS;
					else
						held -= n;
				end
				CMD_REMOVE_MAT: begin
					hit = match_rank(p, d, mp);
					if (hit < 0) begin
						res.status = ST_NOT_FOUND;
					end else begin
						rank = hit;
						for (int i = hit; i + 1 < held; i++) begin
							prio_mem[i] = prio_mem[i+1];
							pay_mem[i] = pay_mem[i+1];
						end
						held--;
					end
				end
				default: begin
					hit = match_rank(p, d, mp);
					if (hit < 0)
						res.status = ST_NOT_FOUND;
					else
						rank = hit;
				end
			endcase
			if (res.status != ST_OK)
				rank = 0;
			res.found_rank = rank[5:0];
			res.entry_count = held[6:0];
			res.is_empty = (held == 0);
			res.top_priority = held > 0 ? prio_mem[held-1] : '0;
			res.top_payload = held > 0 ? pay_mem[held-1] : '0;
			pending.push_back(res);
		endfunction

		function void check_result(queue_result_t act);
			queue_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, act.status);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (act.status !== exp.status) begin
				$display("%0t: status exp %0d got %0d", $time, exp.status, act.status);
				errors++;
			end
			if (act.found_rank !== exp.found_rank) begin
				$display("%0t: found_rank exp %0d got %0d", $time, exp.found_rank,
					act.found_rank);
				errors++;
			end
			if (act.top_priority !== exp.top_priority) begin
				$display("%0t: top_priority exp %h got %h", $time, exp.top_priority,
					act.top_priority);
				errors++;
			end
			if (act.top_payload !== exp.top_payload) begin
				$display("%0t: top_payload exp %h got %h", $time, exp.top_payload,
					act.top_payload);
				errors++;
			end
			if (act.entry_count !== exp.entry_count) begin
				$display("%0t: entry_count exp %0d got %0d", $time, exp.entry_count,
					act.entry_count);
				errors++;
			end
			if (act.is_empty !== exp.is_empty) begin
				$display("%0t: is_empty exp %0d got %0d", $time, exp.is_empty, act.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_FIND;
	logic [31:0] priority_req = 0;
	logic [31:0] payload = 0;
	logic        match_payload = 0;
	logic [6:0]  remove_count = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [5:0]  found_rank;
	logic [31:0] top_priority;
	logic [31:0] top_payload;
	logic [6:0]  entry_count;
	logic        is_empty;

	int send_idle_pct = 9;
	int recv_idle_pct = 59;
	int quiet_cycles = 0;
	queue_scoreboard board;

	sorted_array_priority_queue_core dut (.*);

	always #6 clk = ~clk;

	// Receiver side: check results, stall at random, count quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result('{status, found_rank, top_priority, top_payload,
					entry_count, is_empty});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Valid stays high from one item to the next unless the sender idles.
	task automatic send_command(logic [1:0] c, logic [31:0] p, logic [31:0] d,
			logic mp, logic [6:0] n);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		cmd <= c;
		priority_req <= p;
		payload <= d;
		match_payload <= mp;
		remove_count <= n;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_command(c, p, d, mp, n);
	endtask

	// Small priority pool so duplicates and matches happen often.
	function automatic logic [31:0] pick_priority();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom_range(7);
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [1:0] c;
		logic [6:0] n;
		logic [31:0] d;
		logic mp;
		for (int k = 0; k < count; k++) begin
			c = 2'($urandom_range(3));
			if (board.held < 8 && $urandom_range(1))
				c = CMD_INSERT;
			n = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(3));
			d = $urandom_range(1) ? 32'($urandom_range(3)) : 32'($urandom);
			mp = 1'($urandom_range(1));
			send_command(c, pick_priority(), d, mp, n);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Empty-store cases first.
		send_command(CMD_FIND, 0, 0, 0, 0);
		send_command(CMD_REMOVE_MAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
		send_command(CMD_REMOVE_TOP, 0, 0, 0, 0);
		send_command(CMD_REMOVE_TOP, 0, 0, 0, 7'h7F);
		send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		send_command(CMD_INSERT, 0, 0, 1, 0);
		send_command(CMD_INSERT, 5, 32'hA5A5_5A5A, 0, 0);
		send_command(CMD_INSERT, 5, 32'h5A5A_A5A5, 0, 0);
		send_command(CMD_FIND, 5, 32'hA5A5_5A5A, 1, 0);
		send_command(CMD_FIND, 5, 0, 0, 0);
		send_command(CMD_FIND, 5, 1, 1, 0);
		send_command(CMD_REMOVE_MAT, 5, 32'hA5A5_5A5A, 1, 0);
		send_command(CMD_REMOVE_TOP, 0, 0, 0, 3);
		send_command(CMD_REMOVE_TOP, 0, 0, 0, 4);
		// Fill to full, overflow, then drain with a maximal count.
		for (int i = 0; i < DEPTH; i++)
			send_command(CMD_INSERT, pick_priority(), $urandom, 0, 0);
		send_command(CMD_INSERT, 1, 1, 0, 0);
		send_command(CMD_FIND, 32'hFFFF_FFFF, 0, 0, 0);
		send_command(CMD_REMOVE_TOP, 0, 0, 0, 65);
		send_command(CMD_REMOVE_TOP, 0, 0, 0, 64);
		random_phase(175);
		send_idle_pct = 59;
		recv_idle_pct = 9;
		random_phase(175);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(175);
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
